// File: src/isdb_pkg.sv
package isdb_pkg;

	localparam int DEPTH   = 50;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int WORD_W  = 16;
	localparam int FILL_W  = 7;
	localparam int CTR_W   = 32;
	localparam int AXES    = 6;
	localparam int SMP_W   = AXES * WORD_W;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [SMP_W-1:0] smp_t;

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_DRAIN  = 2'd1,
		MODE_CLEAR  = 2'd2,
		MODE_STATUS = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic [WORD_W-1:0] gyro_x_in;
		logic [WORD_W-1:0] gyro_y_in;
		logic [WORD_W-1:0] gyro_z_in;
		logic [WORD_W-1:0] accel_x_in;
		logic [WORD_W-1:0] accel_y_in;
		logic [WORD_W-1:0] accel_z_in;
		logic [WORD_W-1:0] request_count;
	} in_word_t;

	typedef struct packed {
		logic                     sample_valid;
		logic                     last;
		logic signed [WORD_W-1:0] gyro_x_out;
		logic signed [WORD_W-1:0] gyro_y_out;
		logic signed [WORD_W-1:0] gyro_z_out;
		logic signed [WORD_W-1:0] accel_x_out;
		logic signed [WORD_W-1:0] accel_y_out;
		logic signed [WORD_W-1:0] accel_z_out;
		logic [FILL_W-1:0]        fill_level;
		logic [CTR_W-1:0]         total_pushed;
		logic [CTR_W-1:0]         dropped_total;
	} out_word_t;

	typedef struct packed {
		logic do_push;
		logic do_clear;
		logic do_status;
		logic load_drain;
		logic rd_issue;
	} ctl_t;

	typedef struct packed {
		logic drain_empty;
		logic rd_last;
		logic pipe_busy;
	} sts_t;

endpackage

// File: src/isdb_ctrl.sv
module isdb_ctrl
	import isdb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  mode_t mode,
	input  sts_t  sts,
	output logic  busy,
	output ctl_t  ctl
);

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	state_t state_q;
	state_t state_nx;
	logic   accept;

	assign busy   = (state_q == ST_DRAIN) || sts.pipe_busy;
	assign accept = start && !busy;

	always_comb begin
		ctl      = '0;
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (mode)
						MODE_PUSH: begin
							ctl.do_push   = 1'b1;
							ctl.do_status = 1'b1;
						end
						MODE_DRAIN: begin
							ctl.do_clear = 1'b1;
							if (sts.drain_empty) begin
								ctl.do_status = 1'b1;
							end else begin
								ctl.load_drain = 1'b1;
								state_nx       = ST_DRAIN;
							end
						end
						MODE_CLEAR: begin
							ctl.do_clear  = 1'b1;
							ctl.do_status = 1'b1;
						end
						MODE_STATUS: begin
							ctl.do_status = 1'b1;
						end
						default: begin
							ctl.do_status = 1'b1;
						end
					endcase
				end
			end
			ST_DRAIN: begin
				ctl.rd_issue = 1'b1;
				if (sts.rd_last) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// File: src/isdb_dpath.sv
module isdb_dpath
	import isdb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  cmd,
	input  ctl_t      ctl,
	output sts_t      sts,
	output logic      rsp_valid,
	output out_word_t rsp
);

	smp_t             mem [DEPTH];

	cnt_t             held_q;
	idx_t             oldest_q;
	logic [CTR_W-1:0] push_cnt_q;
	logic [CTR_W-1:0] drop_cnt_q;
	idx_t             rd_ptr_q;
	cnt_t             remain_q;
	smp_t             rd_data_s1;
	logic             sv_s1;
	logic             last_s1;
	out_word_t        rsp_q;
	logic             rsp_valid_q;

	logic             full;
	logic [CNT_W:0]   wr_sum;
	idx_t             wr_slot;
	idx_t             oldest_inc;
	cnt_t             held_nx;
	idx_t             oldest_nx;
	logic [CTR_W-1:0] push_nx;
	logic [CTR_W-1:0] drop_nx;
	logic [WORD_W-1:0] held_ext;
	logic [WORD_W-1:0] take_n;
	smp_t             wr_data;

	assign full       = (held_q == CNT_W'(DEPTH));
	assign wr_sum     = {1'b0, CNT_W'(oldest_q)} + {1'b0, held_q};
	assign wr_slot    = full ? oldest_q
	                  : (wr_sum >= (CNT_W+1)'(DEPTH)) ? IDX_W'(wr_sum - (CNT_W+1)'(DEPTH))
	                  : IDX_W'(wr_sum);
	assign oldest_inc = (oldest_q == IDX_W'(DEPTH - 1)) ? '0 : oldest_q + 1'b1;
	assign wr_data    = {cmd.gyro_x_in, cmd.gyro_y_in, cmd.gyro_z_in,
	                     cmd.accel_x_in, cmd.accel_y_in, cmd.accel_z_in};

	assign held_ext   = WORD_W'(held_q);
	assign take_n     = (cmd.request_count < held_ext) ? cmd.request_count : held_ext;

	assign sts.drain_empty = (take_n == '0);
	assign sts.rd_last     = (remain_q == cnt_t'(1));
	assign sts.pipe_busy   = sv_s1;

	always_comb begin
		held_nx   = held_q;
		oldest_nx = oldest_q;
		push_nx   = push_cnt_q;
		drop_nx   = drop_cnt_q;
		if (ctl.do_push) begin
			push_nx = push_cnt_q + 1'b1;
			if (full) begin
				oldest_nx = oldest_inc;
				drop_nx   = drop_cnt_q + 1'b1;
			end else begin
				held_nx = held_q + 1'b1;
			end
		end
		if (ctl.do_clear) begin
			held_nx   = '0;
			oldest_nx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			oldest_q    <= '0;
			push_cnt_q  <= '0;
			drop_cnt_q  <= '0;
			rd_ptr_q    <= '0;
			remain_q    <= '0;
			sv_s1       <= 1'b0;
			last_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			held_q     <= held_nx;
			oldest_q   <= oldest_nx;
			push_cnt_q <= push_nx;
			drop_cnt_q <= drop_nx;
			sv_s1      <= ctl.rd_issue;
			if (ctl.load_drain) begin
				rd_ptr_q <= oldest_q;
				remain_q <= CNT_W'(take_n);
			end else if (ctl.rd_issue) begin
				rd_ptr_q <= (rd_ptr_q == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
				remain_q <= remain_q - 1'b1;
			end
			if (ctl.rd_issue) begin
				last_s1 <= (remain_q == cnt_t'(1));
			end
			rsp_valid_q <= ctl.do_status || sv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.do_push) begin
			mem[wr_slot] <= wr_data;
		end
		if (ctl.rd_issue) begin
			rd_data_s1 <= mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.do_status) begin
			rsp_q.sample_valid  <= 1'b0;
			rsp_q.last          <= 1'b1;
			rsp_q.gyro_x_out    <= '0;
			rsp_q.gyro_y_out    <= '0;
			rsp_q.gyro_z_out    <= '0;
			rsp_q.accel_x_out   <= '0;
			rsp_q.accel_y_out   <= '0;
			rsp_q.accel_z_out   <= '0;
			rsp_q.fill_level    <= FILL_W'(held_nx);
			rsp_q.total_pushed  <= push_nx;
			rsp_q.dropped_total <= drop_nx;
		end else if (sv_s1) begin
			rsp_q.sample_valid  <= 1'b1;
			rsp_q.last          <= last_s1;
			rsp_q.gyro_x_out    <= rd_data_s1[6*WORD_W-1:5*WORD_W];
			rsp_q.gyro_y_out    <= rd_data_s1[5*WORD_W-1:4*WORD_W];
			rsp_q.gyro_z_out    <= rd_data_s1[4*WORD_W-1:3*WORD_W];
			rsp_q.accel_x_out   <= rd_data_s1[3*WORD_W-1:2*WORD_W];
			rsp_q.accel_y_out   <= rd_data_s1[2*WORD_W-1:WORD_W];
			rsp_q.accel_z_out   <= rd_data_s1[WORD_W-1:0];
			rsp_q.fill_level    <= '0;
			rsp_q.total_pushed  <= push_cnt_q;
			rsp_q.dropped_total <= drop_cnt_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(DEPTH))
		else $error("held count above depth");

	a_oldest_bound: assert property (@(posedge clk) disable iff (!arst_n)
		oldest_q < IDX_W'(DEPTH))
		else $error("oldest index out of range");

	a_issue_remain: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.rd_issue |-> (remain_q != '0))
		else $error("read issued with nothing left");

	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.do_status && sv_s1))
		else $error("status result collides with sample result");

	a_sample_src: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.sample_valid) |-> $past(sv_s1))
		else $error("sample result without a read");

endmodule

// File: src/imu_sample_drop_oldest_buffer.sv
// Drop-oldest buffer of six-axis IMU samples. An item is taken when start is
// high and busy is low. Push, clear, status query and a drain that emits
// nothing each give one result on the rsp ports in the next cycle. A drain
// of n samples keeps busy high while its samples are read out and gives its
// n results in consecutive cycles, the first of them on the ports after the
// drain state register, the memory read register and the result register:
// the single read port of the sample memory delivers one sample per cycle.
// Each result is shown for exactly one cycle, marked by rsp_valid; the
// receiver cannot stall, so it must take every result as it appears.
module imu_sample_drop_oldest_buffer
	import isdb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_word_t  cmd,
	output logic      rsp_valid,
	output out_word_t rsp
);

	ctl_t ctl;
	sts_t sts;

	isdb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (cmd.mode),
		.sts    (sts),
		.busy   (busy),
		.ctl    (ctl)
	);

	isdb_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ctl       (ctl),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

// File: verif/imu_sample_drop_oldest_buffer_test.sv
module imu_sample_drop_oldest_buffer_test;
	import isdb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 290;
	localparam int QUIET_LIMIT  = 600;

	typedef struct {
		in_word_t  w;
		bit        typed;
		out_word_t want;
	} plan_row_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	in_word_t  cmd = '0;
	logic      busy;
	logic      rsp_valid;
	out_word_t rsp;

	imu_sample_drop_oldest_buffer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	smp_t        shadow_mem [DEPTH];
	int unsigned sh_oldest = 0;
	int unsigned sh_held = 0;
	logic [31:0] sh_pushed = '0;
	logic [31:0] sh_dropped = '0;

	out_word_t   owed_words [$];
	plan_row_t   plan [$];
	int unsigned mismatches = 0;
	int unsigned items_taken = 0;
	int unsigned samples_out = 0;
	int unsigned quiet_cycles = 0;
	int unsigned burst_left = 0;
	out_word_t   head_word;

	function automatic in_word_t make_cmd(mode_t m, smp_t axes, logic [WORD_W-1:0] req);
		in_word_t w;
		w.mode = m;
		{w.gyro_x_in, w.gyro_y_in, w.gyro_z_in,
		 w.accel_x_in, w.accel_y_in, w.accel_z_in} = axes;
		w.request_count = req;
		return w;
	endfunction

	function automatic out_word_t status_word(int unsigned fill, logic [31:0] pushed,
			logic [31:0] dropped);
		out_word_t r;
		r = '0;
		r.last = 1'b1;
		r.fill_level = FILL_W'(fill);
		r.total_pushed = pushed;
		r.dropped_total = dropped;
		return r;
	endfunction

	function automatic smp_t rand_axes();
		return {$urandom, $urandom, $urandom};
	endfunction

	// advance the shadow buffer by one command and owe its readouts
	task automatic shadow_apply(in_word_t w);
		int unsigned slot;
		int unsigned n;
		out_word_t r;
		case (w.mode)
		MODE_PUSH: begin
			if (sh_held < DEPTH) begin
				slot = (sh_oldest + sh_held) % DEPTH;
				sh_held++;
			end else begin
				slot = sh_oldest;
				sh_oldest = (sh_oldest + 1) % DEPTH;
				sh_dropped++;
			end
			shadow_mem[slot] = {w.gyro_x_in, w.gyro_y_in, w.gyro_z_in,
				w.accel_x_in, w.accel_y_in, w.accel_z_in};
			sh_pushed++;
			owed_words.push_back(status_word(sh_held, sh_pushed, sh_dropped));
		end
		MODE_DRAIN: begin
			n = (w.request_count < sh_held) ? w.request_count : sh_held;
			for (int i = 0; i < n; i++) begin
				r = status_word(0, sh_pushed, sh_dropped);
				r.sample_valid = 1'b1;
				r.last = (i == n - 1);
				{r.gyro_x_out, r.gyro_y_out, r.gyro_z_out,
				 r.accel_x_out, r.accel_y_out, r.accel_z_out} =
					shadow_mem[(sh_oldest + i) % DEPTH];
				owed_words.push_back(r);
			end
			sh_held = 0;
			sh_oldest = 0;
			if (n == 0)
				owed_words.push_back(status_word(0, sh_pushed, sh_dropped));
		end
		MODE_CLEAR: begin
			sh_held = 0;
			sh_oldest = 0;
			owed_words.push_back(status_word(0, sh_pushed, sh_dropped));
		end
		default: begin
			owed_words.push_back(status_word(sh_held, sh_pushed, sh_dropped));
		end
		endcase
	endtask

	task automatic issue(in_word_t w, bit typed, out_word_t want);
		start <= 1'b1;
		cmd <= w;
		do @(posedge clk); while (busy);
		shadow_apply(w);
		if (typed)
			owed_words[$] = want;
		items_taken++;
		// hold off between bursts
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 10);
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end else begin
			burst_left--;
		end
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && rsp_valid !== 1'b0) begin
			if (owed_words.size() == 0) begin
				$error("result word with nothing owed: %p", rsp);
				mismatches++;
			end else begin
				head_word = owed_words.pop_front();
				check_field("sample_valid", 32'(head_word.sample_valid),
					32'(rsp.sample_valid));
				check_field("last", 32'(head_word.last), 32'(rsp.last));
				check_field("gyro_x_out", 32'(head_word.gyro_x_out), 32'(rsp.gyro_x_out));
				check_field("gyro_y_out", 32'(head_word.gyro_y_out), 32'(rsp.gyro_y_out));
				check_field("gyro_z_out", 32'(head_word.gyro_z_out), 32'(rsp.gyro_z_out));
				check_field("accel_x_out", 32'(head_word.accel_x_out),
					32'(rsp.accel_x_out));
				check_field("accel_y_out", 32'(head_word.accel_y_out),
					32'(rsp.accel_y_out));
				check_field("accel_z_out", 32'(head_word.accel_z_out),
					32'(rsp.accel_z_out));
				check_field("fill_level", 32'(head_word.fill_level), 32'(rsp.fill_level));
				check_field("total_pushed", head_word.total_pushed, rsp.total_pushed);
				check_field("dropped_total", head_word.dropped_total, rsp.dropped_total);
				if (rsp.sample_valid === 1'b1)
					samples_out++;
			end
		end
		if ((start && !busy) || rsp_valid === 1'b1)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
			$display("imu_sample_drop_oldest_buffer test failed");
			$finish;
		end
	end

	initial begin
		int unsigned pushes;
		int unsigned base;
		logic [WORD_W-1:0] req;

		plan.push_back('{make_cmd(MODE_STATUS, '0, '0), 1'b1, status_word(0, 0, 0)});
		plan.push_back('{make_cmd(MODE_DRAIN, '1, 16'hFFFF), 1'b1, status_word(0, 0, 0)});
		plan.push_back('{make_cmd(MODE_CLEAR, '1, 16'hFFFF), 1'b1, status_word(0, 0, 0)});
		plan.push_back('{make_cmd(MODE_PUSH, '1, '0), 1'b1, status_word(1, 1, 0)});
		plan.push_back('{make_cmd(MODE_PUSH, '0, '1), 1'b1, status_word(2, 2, 0)});
		plan.push_back('{make_cmd(MODE_PUSH, {6{16'h8000}}, '0), 1'b1,
			status_word(3, 3, 0)});
		plan.push_back('{make_cmd(MODE_PUSH, {6{16'h7FFF}}, '0), 1'b1,
			status_word(4, 4, 0)});
		plan.push_back('{make_cmd(MODE_DRAIN, '0, 16'd3), 1'b0, '0});
		plan.push_back('{make_cmd(MODE_STATUS, '0, '0), 1'b1, status_word(0, 4, 0)});
		plan.push_back('{make_cmd(MODE_PUSH, 96'h0001_8000_7FFF_FFFF_1234_ABCD, '0), 1'b1,
			status_word(1, 5, 0)});
		plan.push_back('{make_cmd(MODE_DRAIN, '0, 16'd0), 1'b1, status_word(0, 5, 0)});
		plan.push_back('{make_cmd(MODE_DRAIN, '0, 16'd1), 1'b1, status_word(0, 5, 0)});
		plan.push_back('{make_cmd(MODE_PUSH, 96'hAAAA_5555_AAAA_5555_AAAA_5555, '0), 1'b1,
			status_word(1, 6, 0)});
		plan.push_back('{make_cmd(MODE_PUSH, 96'h5555_AAAA_5555_AAAA_5555_AAAA, '0), 1'b1,
			status_word(2, 7, 0)});
		plan.push_back('{make_cmd(MODE_CLEAR, '0, '0), 1'b1, status_word(0, 7, 0)});
		plan.push_back('{make_cmd(MODE_PUSH, 96'hFEDC_BA98_7654_3210_0F0F_F0F0, '0), 1'b1,
			status_word(1, 8, 0)});
		plan.push_back('{make_cmd(MODE_PUSH, 96'h8001_7FFE_0002_FFFD_C000_3FFF, '0), 1'b1,
			status_word(2, 9, 0)});
		plan.push_back('{make_cmd(MODE_DRAIN, '0, 16'hFFFF), 1'b0, '0});
		plan.push_back('{make_cmd(MODE_PUSH, 96'h1111_2222_3333_4444_5555_6666, '0), 1'b0,
			'0});
		plan.push_back('{make_cmd(MODE_PUSH, 96'h7777_8888_9999_AAAA_BBBB_CCCC, '0), 1'b0,
			'0});
		plan.push_back('{make_cmd(MODE_DRAIN, '0, 16'd1), 1'b0, '0});

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			issue(plan[i].w, plan[i].typed, plan[i].want);

		base = items_taken;
		while (items_taken - base < RANDOM_ITEMS) begin
			if ($urandom_range(0, 4) != 0) begin
				pushes = ($urandom_range(0, 3) == 0) ? $urandom_range(DEPTH - 2, DEPTH + 14)
					: $urandom_range(0, 12);
				for (int i = 0; i < pushes; i++) begin
					if ($urandom_range(0, 9) == 0)
						issue(make_cmd(MODE_STATUS, rand_axes(), WORD_W'($urandom)),
							1'b0, '0);
					issue(make_cmd(MODE_PUSH, rand_axes(), WORD_W'($urandom)), 1'b0, '0);
				end
				case ($urandom_range(0, 3))
				0: req = '0;
				1: req = WORD_W'($urandom_range(1, pushes + 1));
				2: req = '1;
				default: req = WORD_W'($urandom);
				endcase
				issue(make_cmd(MODE_DRAIN, rand_axes(), req), 1'b0, '0);
			end else begin
				repeat ($urandom_range(1, 4))
					issue(make_cmd(mode_t'($urandom_range(0, 3)), rand_axes(),
						WORD_W'($urandom)), 1'b0, '0);
			end
		end

		start <= 1'b0;
		while (owed_words.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 4) @(posedge clk);

		$display("ran %0d commands: %0d samples drained, %0d pushes, %0d overwrites on full",
			items_taken, samples_out, sh_pushed, sh_dropped);
		if (mismatches == 0)
			$display("imu_sample_drop_oldest_buffer test passed");
		else
			$display("imu_sample_drop_oldest_buffer test failed");
		$finish;
	end

endmodule
